>>> hdl/multi_policy_transition_arbiter_top_defines.svh
// assertion helpers shared by the arbiter checks
`ifndef MULTI_POLICY_TRANSITION_ARBITER_TOP_DEFINES_SVH
`define MULTI_POLICY_TRANSITION_ARBITER_TOP_DEFINES_SVH

// same-cycle implication, masked during reset
`define MPTA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define MPTA_ASSERT_NEXT(lbl, clk, ante, cons, rst, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also runs through reset
`define MPTA_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/mpta_pkg.sv
`default_nettype none

package mpta_pkg;

   // fixed field widths
   localparam int MASK_W       = 16;
   localparam int START_W      = 4;
   localparam int INDEX_W      = 4;
   localparam int COUNT_W      = 5;
   localparam int PRIO_FIELD_W = 4;
   localparam int TABLE_W      = 64;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 64;

   // reset values
   localparam logic [COUNT_W-1:0] COUNT_RESET   = 5'd16;
   localparam logic [INDEX_W-1:0] POINTER_RESET = 4'hF;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_POLICY_MODE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REQUESTER_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRIORITY_TABLE  = 2'd2;

   typedef enum logic [1:0] {
      POLICY_LOWEST      = 2'd0,
      POLICY_PRIORITY    = 2'd1,
      POLICY_ROUND_ROBIN = 2'd2,
      POLICY_RANDOM      = 2'd3
   } policy_type;

   typedef struct packed {
      policy_type           policy;
      logic [COUNT_W-1:0]   count;
      logic [TABLE_W-1:0]   prio;
   } cfg_type;

   typedef struct packed {
      logic                 grant_valid;
      logic [INDEX_W-1:0]   grant_index;
   } grant_type;

   // index of the lowest set bit, zero for an empty mask
   function automatic logic [INDEX_W-1:0] lowest_set(input logic [MASK_W-1:0] m);
      logic [INDEX_W-1:0] idx;
      idx = '0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if (m[i]) begin
            idx = INDEX_W'(i);
         end
      end
      return idx;
   endfunction

   // a mod n for a 4-bit a and n >= 1, restoring compare-subtract
   function automatic logic [START_W-1:0] mod_small(input logic [START_W-1:0] a,
                                                    input logic [COUNT_W-1:0] n);
      logic [START_W-1:0] r;
      logic [8:0]         d;
      r = a;
      for (int s = 3; s >= 0; s--) begin
         d = 9'(n) << s;
         if (9'(r) >= d) begin
            r = r - d[START_W-1:0];
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hdl/multi_policy_transition_arbiter_top.sv
// Path: an accepted request passes the input register, then the result register, which
// drives its grant on rsp_.
// Throughput: one request per cycle while rsp_ready does not stall the result register; the
// combinational pick between the two registers, with the round-robin pointer update, sets that rate.
// Reset (synchronous, active high): both stages empty, policy lowest index,
// requester count 16, priorities zero, round-robin pointer 15.
`default_nettype none

module multi_policy_transition_arbiter_top #(
   parameter int NUM_REQUESTERS = 16,
   parameter int PRIORITY_BITS  = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [mpta_pkg::MASK_W-1:0]         req_enabled_mask,
   input  wire logic [mpta_pkg::START_W-1:0]        req_random_start,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_grant_valid,
   output logic [mpta_pkg::INDEX_W-1:0]             rsp_grant_index,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [mpta_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [mpta_pkg::CSR_DATA_W-1:0]     csr_data
);

   mpta_pkg::cfg_type              cfg;
   mpta_pkg::grant_type            grant;
   logic [mpta_pkg::INDEX_W-1:0]   pointer_next;

   logic                           s1_valid_ff;
   logic [mpta_pkg::MASK_W-1:0]    s1_mask_ff;
   logic [mpta_pkg::START_W-1:0]   s1_start_ff;
   logic [mpta_pkg::INDEX_W-1:0]   pointer_ff;
   logic                           rsp_valid_ff;
   mpta_pkg::grant_type            rsp_grant_ff;

   logic                           s2_open;
   logic                           s1_move;
   logic                           req_take;

   // configuration registers
   mpta_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // policy pick on the input register
   mpta_pick #(
      .NUM_REQUESTERS (NUM_REQUESTERS),
      .PRIORITY_BITS  (PRIORITY_BITS)
   ) u_pick (
      .cfg          (cfg),
      .enabled_mask (s1_mask_ff),
      .random_start (s1_start_ff),
      .pointer      (pointer_ff),
      .grant        (grant),
      .pointer_next (pointer_next)
   );

   // stage handshakes
   assign s2_open   = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && s2_open;
   assign req_ready = !s1_valid_ff || s2_open;
   assign req_take  = req_valid && req_ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mask_ff  <= req_enabled_mask;
         s1_start_ff <= req_random_start;
      end
   end

   // round-robin pointer, updated as a request leaves the input register in round-robin mode
   always_ff @(posedge clock) begin
      if (reset) begin
         pointer_ff <= mpta_pkg::POINTER_RESET;
      end else if (s1_move) begin
         pointer_ff <= pointer_next;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_open) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_grant_ff <= grant;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_grant_valid = rsp_grant_ff.grant_valid;
   assign rsp_grant_index = rsp_grant_ff.grant_index;

endmodule

`default_nettype wire

>>> hdl/mpta_csr.sv
`default_nettype none

module mpta_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [mpta_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [mpta_pkg::CSR_DATA_W-1:0]     csr_data,
   output mpta_pkg::cfg_type                        cfg
);

   mpta_pkg::cfg_type cfg_ff;
   mpta_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register write decode, unknown indexes dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mpta_pkg::CSR_POLICY_MODE:
               cfg_in.policy = mpta_pkg::policy_type'(csr_data[1:0]);
            mpta_pkg::CSR_REQUESTER_COUNT:
               cfg_in.count = csr_data[mpta_pkg::COUNT_W-1:0];
            mpta_pkg::CSR_PRIORITY_TABLE:
               cfg_in.prio = csr_data[mpta_pkg::TABLE_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.policy <= mpta_pkg::POLICY_LOWEST;
         cfg_ff.count  <= mpta_pkg::COUNT_RESET;
         cfg_ff.prio   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/mpta_pick.sv
`default_nettype none

module mpta_pick #(
   parameter int NUM_REQUESTERS = 16,
   parameter int PRIORITY_BITS  = 4
) (
   input  wire mpta_pkg::cfg_type                cfg,
   input  wire logic [mpta_pkg::MASK_W-1:0]      enabled_mask,
   input  wire logic [mpta_pkg::START_W-1:0]     random_start,
   input  wire logic [mpta_pkg::INDEX_W-1:0]     pointer,
   output mpta_pkg::grant_type                   grant,
   output logic [mpta_pkg::INDEX_W-1:0]          pointer_next
);

   localparam int NUM_LEVELS = 2 ** PRIORITY_BITS;

   logic [mpta_pkg::COUNT_W-1:0]  count_eff;
   logic [mpta_pkg::MASK_W-1:0]   mask_eff;
   logic [mpta_pkg::INDEX_W-1:0]  ptr_adv;
   logic [mpta_pkg::START_W-1:0]  start;
   logic [mpta_pkg::MASK_W-1:0]   upper;
   logic [mpta_pkg::INDEX_W-1:0]  wrap_idx;
   logic [PRIORITY_BITS-1:0]      prio_arr [mpta_pkg::MASK_W];
   logic [NUM_LEVELS-1:0]         level_hit;
   logic [PRIORITY_BITS-1:0]      best;
   logic [mpta_pkg::MASK_W-1:0]   best_sel;
   logic [mpta_pkg::INDEX_W-1:0]  prio_idx;
   logic                          found;
   logic [mpta_pkg::INDEX_W-1:0]  idx;

   // requesters in use, count clamped to one and to the array size
   always_comb begin
      if (cfg.count == '0) begin
         count_eff = mpta_pkg::COUNT_W'(1);
      end else if (cfg.count > mpta_pkg::COUNT_W'(NUM_REQUESTERS)) begin
         count_eff = mpta_pkg::COUNT_W'(NUM_REQUESTERS);
      end else begin
         count_eff = cfg.count;
      end
      for (int i = 0; i < mpta_pkg::MASK_W; i++) begin
         mask_eff[i] = enabled_mask[i] && (mpta_pkg::COUNT_W'(i) < count_eff);
      end
      found = |mask_eff;
   end

   // round-robin pointer step, back to zero at the last slot
   always_comb begin
      if ({1'b0, pointer} >= (count_eff - mpta_pkg::COUNT_W'(1))) begin
         ptr_adv = '0;
      end else begin
         ptr_adv = pointer + mpta_pkg::INDEX_W'(1);
      end
   end

   // shared wrapping search from the policy's start slot
   always_comb begin
      case (cfg.policy)
         mpta_pkg::POLICY_ROUND_ROBIN: start = ptr_adv;
         mpta_pkg::POLICY_RANDOM:      start = mpta_pkg::mod_small(random_start, count_eff);
         default:                      start = '0;
      endcase
      upper = mask_eff & ({mpta_pkg::MASK_W{1'b1}} << start);
      if (|upper) begin
         wrap_idx = mpta_pkg::lowest_set(upper);
      end else begin
         wrap_idx = mpta_pkg::lowest_set(mask_eff);
      end
   end

   // priority pick: highest level present, then lowest index at that level
   always_comb begin
      for (int i = 0; i < mpta_pkg::MASK_W; i++) begin
         prio_arr[i] = cfg.prio[mpta_pkg::PRIO_FIELD_W*i +: PRIORITY_BITS];
      end
      for (int p = 0; p < NUM_LEVELS; p++) begin
         level_hit[p] = 1'b0;
         for (int i = 0; i < mpta_pkg::MASK_W; i++) begin
            if (mask_eff[i] && (prio_arr[i] == PRIORITY_BITS'(p))) begin
               level_hit[p] = 1'b1;
            end
         end
      end
      best = '0;
      for (int p = 0; p < NUM_LEVELS; p++) begin
         if (level_hit[p]) begin
            best = PRIORITY_BITS'(p);
         end
      end
      for (int i = 0; i < mpta_pkg::MASK_W; i++) begin
         best_sel[i] = mask_eff[i] && (prio_arr[i] == best);
      end
      prio_idx = mpta_pkg::lowest_set(best_sel);
   end

   // result and pointer update
   always_comb begin
      idx = (cfg.policy == mpta_pkg::POLICY_PRIORITY) ? prio_idx : wrap_idx;
      grant.grant_valid = found;
      grant.grant_index = found ? idx : '0;
      if (cfg.policy == mpta_pkg::POLICY_ROUND_ROBIN) begin
         pointer_next = found ? idx : ptr_adv;
      end else begin
         pointer_next = pointer;
      end
   end

endmodule

`default_nettype wire

>>> hdl/mpta_checker.sv
`default_nettype none

`include "multi_policy_transition_arbiter_top_defines.svh"

module mpta_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic                            rsp_grant_valid,
   input wire logic [mpta_pkg::INDEX_W-1:0]    rsp_grant_index
);

   // no grant always reports index zero
   `MPTA_ASSERT_NOW(a_no_grant_index_zero, clock, reset, rsp_valid && !rsp_grant_valid, rsp_grant_index == '0, "no-grant result with nonzero index")

   // reset empties the result register
   `MPTA_ASSERT_ALWAYS_NEXT(a_reset_clears_rsp, clock, reset, !rsp_valid, "result valid right after reset")

   // a stalled result holds
   `MPTA_ASSERT_NEXT(a_rsp_hold, clock, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_grant_valid) && $stable(rsp_grant_index), reset, "stalled result changed")

   // an idle pipeline always takes a request
   `MPTA_ASSERT_NOW(a_idle_ready, clock, reset, !rsp_valid && !$past(req_valid && req_ready), req_ready, "request refused while pipeline empty")

endmodule

bind multi_policy_transition_arbiter_top mpta_checker u_mpta_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_grant_valid (rsp_grant_valid),
   .rsp_grant_index (rsp_grant_index)
);

`default_nettype wire
